@@ src/ptbt_pkg.sv @@
`default_nettype none
package ptbt_pkg;

   localparam int RING_DEPTH = 64;
   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int TW = 40;
   localparam int SW = 45 + CNT_W;
   localparam int DIV_W = TW + 3;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] REQ_RECORD = 2'd0;
   localparam logic [1:0] REQ_LONGEST = 2'd1;
   localparam logic [1:0] REQ_DELAY = 2'd2;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET = 2'd1;

   localparam logic [TW-1:0] WINDOW_RESET = 40'd1000000;
   localparam logic [TW-1:0] BUDGET_RESET = 40'd200000;
   localparam logic [TW-1:0] TICK_MASK = '1;

   typedef logic signed [SW-1:0] wide_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LATCH,
      CMD_DROP_RD,
      CMD_DROP_CHK,
      CMD_STORE,
      CMD_T_INIT,
      CMD_LIM,
      CMD_WALK,
      CMD_EVAL,
      CMD_DIV_INIT,
      CMD_DIV,
      CMD_STEP,
      CMD_CHK,
      CMD_SCAN_INIT,
      CMD_SCAN,
      CMD_FIN
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       expired;
      logic       walk_done;
      logic       fits;
      logic       div_ok;
      logic       div_done;
      logic       t_le0;
      logic       hit;
      logic       rsp_free;
   } stat_type;

   function automatic wide_type ext(input logic [TW-1:0] x);
      return signed'({{(SW - TW){1'b0}}, x});
   endfunction

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

endpackage
`default_nettype wire

@@ src/ptbt_ctrl.sv @@
`default_nettype none
module ptbt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ptbt_pkg::stat_type stat,
   output ptbt_pkg::cmd_type  cmd
);
   import ptbt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DROP_RD, ST_DROP_CHK, ST_STORE, ST_T_INIT, ST_LIM, ST_WALK,
      ST_EVAL, ST_DIV_INIT, ST_DIV, ST_STEP, ST_CHK, ST_SCAN_INIT, ST_SCAN, ST_FIN
   } state_type;

   state_type state_ff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.op = CMD_NONE;
      case (state_ff)
         ST_IDLE:      cmd.op = req_valid ? CMD_LATCH : CMD_NONE;
         ST_DROP_RD:   cmd.op = CMD_DROP_RD;
         ST_DROP_CHK:  cmd.op = CMD_DROP_CHK;
         ST_STORE:     cmd.op = CMD_STORE;
         ST_T_INIT:    cmd.op = CMD_T_INIT;
         ST_LIM:       cmd.op = CMD_LIM;
         ST_WALK:      cmd.op = CMD_WALK;
         ST_EVAL:      cmd.op = CMD_EVAL;
         ST_DIV_INIT:  cmd.op = CMD_DIV_INIT;
         ST_DIV:       cmd.op = CMD_DIV;
         ST_STEP:      cmd.op = CMD_STEP;
         ST_CHK:       cmd.op = CMD_CHK;
         ST_SCAN_INIT: cmd.op = CMD_SCAN_INIT;
         ST_SCAN:      cmd.op = CMD_SCAN;
         ST_FIN:       cmd.op = stat.rsp_free ? CMD_FIN : CMD_NONE;
         default:      cmd.op = CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_DROP_RD;
               end
            end
            ST_DROP_RD: state_ff <= ST_DROP_CHK;
            ST_DROP_CHK: begin
               if (stat.kind == REQ_UNKNOWN) begin
                  state_ff <= ST_FIN;
               end else if (stat.expired) begin
                  state_ff <= ST_DROP_RD;
               end else if (stat.kind == REQ_RECORD) begin
                  state_ff <= ST_STORE;
               end else begin
                  state_ff <= ST_T_INIT;
               end
            end
            ST_STORE:  state_ff <= ST_FIN;
            ST_T_INIT: state_ff <= ST_LIM;
            ST_LIM:    state_ff <= ST_WALK;
            ST_WALK: begin
               if (stat.walk_done) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               if (stat.fits) begin
                  state_ff <= ST_FIN;
               end else if (stat.kind == REQ_LONGEST) begin
                  state_ff <= stat.div_ok ? ST_DIV_INIT : ST_STEP;
               end else begin
                  state_ff <= ST_SCAN_INIT;
               end
            end
            ST_DIV_INIT: state_ff <= ST_DIV;
            ST_DIV: begin
               if (stat.div_done) begin
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: state_ff <= ST_CHK;
            ST_CHK:  state_ff <= stat.t_le0 ? ST_FIN : ST_LIM;
            ST_SCAN_INIT: state_ff <= ST_SCAN;
            ST_SCAN: begin
               if (stat.hit || stat.walk_done) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (stat.rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ src/ptbt_datapath.sv @@
`default_nettype none
module ptbt_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  ptbt_pkg::cmd_type                cmd,
   output ptbt_pkg::stat_type               stat,
   input  logic [1:0]                       req_type,
   input  logic [ptbt_pkg::TW-1:0]          req_time_first,
   input  logic [ptbt_pkg::TW-1:0]          req_time_second,
   input  logic                             csr_we,
   input  logic [ptbt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ptbt_pkg::TW-1:0]          csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ptbt_pkg::TW-1:0]          rsp_answer_time,
   output logic                             rsp_none_allowed,
   output logic                             rsp_oldest_dropped
);
   import ptbt_pkg::*;

   localparam wide_type WZERO = '0;

   logic [TW-1:0]       win_ff, bud_ff;
   logic [1:0]          kind_ff;
   logic [TW-1:0]       first_ff, second_ff;
   logic [SLOT_W-1:0]   newest_ff, oldest_ff, ptr_ff, rd_addr;
   logic [CNT_W-1:0]    count_ff, k_ff;
   logic                pend_ff;
   logic [2*TW-1:0]     mem [RING_DEPTH];
   logic [2*TW-1:0]     rd_ff;
   wide_type            t_ff, lim_ff, sum_ff, d_ff, floor_ff, num_ff;
   logic [1:0]          inside_ff;
   logic                have_ff;
   logic [DIV_W-1:0]    dvd_ff;
   logic [SW-1:0]       rem_ff;
   logic [DIV_CNT_W-1:0] dcnt_ff;
   logic                qnz_ff, div_used_ff;
   logic [TW-1:0]       ans_ff;
   logic                none_ff, dropf_ff;
   logic                rsp_valid_ff, rsp_none_ff, rsp_drop_ff;
   logic [TW-1:0]       rsp_ans_ff;

   wide_type            now_s, win_s, bud_s, st_s, en_s, part, d_comb, dnew, r;
   wide_type            floor_a, floor_b;
   logic                have_a, have_b;
   logic                issue, hit, fits;
   logic [SW-1:0]       rem_sh, d_u;
   logic [TW-1:0]       r_clamp;
   logic                store_we;
   logic [SLOT_W-1:0]   store_slot;

   always_comb begin
      now_s = ext((kind_ff == REQ_RECORD) ? second_ff : first_ff);
      win_s = ext(win_ff);
      bud_s = ext(bud_ff);
      st_s = ext(rd_ff[2*TW-1:TW]);
      en_s = ext(rd_ff[TW-1:0]);
      if (en_s <= lim_ff) begin
         part = WZERO;
      end else if (st_s > lim_ff) begin
         part = en_s - st_s;
      end else begin
         part = en_s - lim_ff;
      end
      floor_a = floor_ff;
      have_a = have_ff;
      if (st_s <= lim_ff && (!have_ff || st_s > floor_ff)) begin
         floor_a = st_s;
         have_a = 1'b1;
      end
      floor_b = floor_a;
      have_b = have_a;
      if (en_s <= lim_ff && (!have_a || en_s > floor_a)) begin
         floor_b = en_s;
         have_b = 1'b1;
      end
      issue = (k_ff != count_ff);
      d_comb = t_ff + sum_ff - bud_s;
      fits = (d_comb <= WZERO);
      dnew = d_ff - part;
      hit = pend_ff && (en_s > lim_ff) && (dnew <= WZERO);
      r = en_s + dnew + win_s - t_ff - now_s;
      if (r < WZERO) begin
         r_clamp = '0;
      end else if (r > ext(TICK_MASK)) begin
         r_clamp = TICK_MASK;
      end else begin
         r_clamp = r[TW-1:0];
      end
      d_u = d_ff;
      rem_sh = {rem_ff[SW-2:0], dvd_ff[DIV_W-1]};
      rd_addr = (cmd.op == CMD_DROP_RD) ? oldest_ff : ptr_ff;
      store_we = (cmd.op == CMD_STORE);
      store_slot = slot_inc(newest_ff);
   end

   always_comb begin
      stat.kind = kind_ff;
      stat.expired = (count_ff != '0) && (en_s <= now_s - win_s);
      stat.walk_done = !issue && !pend_ff;
      stat.fits = fits;
      stat.div_ok = (inside_ff == 2'd1) && have_ff;
      stat.div_done = (dcnt_ff == '0);
      stat.t_le0 = (t_ff <= WZERO);
      stat.hit = hit;
      stat.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         mem[store_slot] <= {first_ff, second_ff};
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= WINDOW_RESET;
         bud_ff <= BUDGET_RESET;
         newest_ff <= '0;
         oldest_ff <= SLOT_W'(1 % RING_DEPTH);
         count_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW: win_ff <= csr_wdata;
               CSR_BUDGET: bud_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && cmd.op != CMD_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            CMD_LATCH: begin
               kind_ff <= req_type;
               first_ff <= req_time_first;
               second_ff <= req_time_second;
               ans_ff <= '0;
               none_ff <= 1'b0;
               dropf_ff <= 1'b0;
            end
            CMD_DROP_CHK: begin
               if (stat.expired && kind_ff != REQ_UNKNOWN) begin
                  oldest_ff <= slot_inc(oldest_ff);
                  count_ff <= count_ff - 1'b1;
               end
            end
            CMD_STORE: begin
               newest_ff <= store_slot;
               if (count_ff == CNT_W'(RING_DEPTH)) begin
                  oldest_ff <= slot_inc(oldest_ff);
                  dropf_ff <= 1'b1;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            CMD_T_INIT: begin
               if (kind_ff == REQ_DELAY && second_ff < bud_ff) begin
                  t_ff <= ext(second_ff);
               end else begin
                  t_ff <= bud_s;
               end
            end
            CMD_LIM: begin
               lim_ff <= now_s + t_ff - win_s;
               ptr_ff <= oldest_ff;
               k_ff <= '0;
               pend_ff <= 1'b0;
               sum_ff <= WZERO;
               inside_ff <= 2'd0;
               have_ff <= 1'b0;
               floor_ff <= WZERO;
            end
            CMD_WALK: begin
               if (issue) begin
                  ptr_ff <= slot_inc(ptr_ff);
                  k_ff <= k_ff + 1'b1;
               end
               pend_ff <= issue;
               if (pend_ff) begin
                  sum_ff <= sum_ff + part;
                  if (st_s <= lim_ff && lim_ff < en_s && inside_ff != 2'd2) begin
                     inside_ff <= inside_ff + 1'b1;
                  end
                  floor_ff <= floor_b;
                  have_ff <= have_b;
               end
            end
            CMD_EVAL: begin
               d_ff <= d_comb;
               div_used_ff <= 1'b0;
               if (fits && kind_ff == REQ_LONGEST) begin
                  ans_ff <= t_ff[TW-1:0];
               end
            end
            CMD_DIV_INIT: begin
               num_ff <= lim_ff - floor_ff;
               dvd_ff <= DIV_W'(lim_ff - floor_ff);
               rem_ff <= '0;
               dcnt_ff <= DIV_CNT_W'(DIV_W);
               qnz_ff <= 1'b0;
               div_used_ff <= 1'b1;
            end
            CMD_DIV: begin
               if (dcnt_ff != '0) begin
                  if (rem_sh >= d_u) begin
                     rem_ff <= rem_sh - d_u;
                     qnz_ff <= 1'b1;
                  end else begin
                     rem_ff <= rem_sh;
                  end
                  dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b0};
                  dcnt_ff <= dcnt_ff - 1'b1;
               end
            end
            CMD_STEP: begin
               if (div_used_ff && qnz_ff) begin
                  t_ff <= t_ff - num_ff + signed'(rem_ff);
               end else begin
                  t_ff <= t_ff - d_ff;
               end
            end
            CMD_CHK: begin
               if (t_ff <= WZERO) begin
                  none_ff <= 1'b1;
               end
            end
            CMD_SCAN_INIT: begin
               ptr_ff <= oldest_ff;
               k_ff <= '0;
               pend_ff <= 1'b0;
            end
            CMD_SCAN: begin
               if (issue) begin
                  ptr_ff <= slot_inc(ptr_ff);
                  k_ff <= k_ff + 1'b1;
               end
               pend_ff <= issue;
               if (pend_ff && en_s > lim_ff) begin
                  d_ff <= dnew;
               end
               if (hit) begin
                  ans_ff <= r_clamp;
               end
            end
            CMD_FIN: begin
               rsp_valid_ff <= 1'b1;
               rsp_ans_ff <= ans_ff;
               rsp_none_ff <= none_ff;
               rsp_drop_ff <= dropf_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_answer_time = rsp_ans_ff;
   assign rsp_none_allowed = rsp_none_ff;
   assign rsp_oldest_dropped = rsp_drop_ff;
endmodule
`default_nettype wire

@@ src/pause_time_budget_tracker.sv @@
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   req_type, req_time_first, req_time_second
// rsp       out        rsp_valid / rsp_ready   rsp_answer_time, rsp_none_allowed,
//                                              rsp_oldest_dropped
// csr       in         csr_we                  csr_index, csr_wdata
//
// One item at a time. Each expired entry takes a read and a check on the single ring read port.
// Record: expiry, then a store. Delay: a budget walk, plus a scan walk if over budget.
// Longest pause: one ring walk per shrink pass, plus the radix-2 divider when used.
// Reset is synchronous; no ring clearing pass, only pointers, count, CSRs, pend and valid flags.
// A waiting result does not block the next item; only the final hand-off waits on rsp_ready.
`default_nettype none
module pause_time_budget_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_type,
   input  logic [ptbt_pkg::TW-1:0]         req_time_first,
   input  logic [ptbt_pkg::TW-1:0]         req_time_second,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ptbt_pkg::TW-1:0]         rsp_answer_time,
   output logic                            rsp_none_allowed,
   output logic                            rsp_oldest_dropped,
   input  logic                            csr_we,
   input  logic [ptbt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ptbt_pkg::TW-1:0]         csr_wdata
);
   import ptbt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ptbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptbt_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_type           (req_type),
      .req_time_first     (req_time_first),
      .req_time_second    (req_time_second),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_answer_time    (rsp_answer_time),
      .rsp_none_allowed   (rsp_none_allowed),
      .rsp_oldest_dropped (rsp_oldest_dropped)
   );
endmodule
`default_nettype wire

@@ src/ptbt_checker.sv @@
`default_nettype none
module ptbt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ptbt_pkg::TW-1:0]        rsp_answer_time,
   input logic                           rsp_none_allowed,
   input logic                           rsp_oldest_dropped
);
   import ptbt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_answer_time))
      else $error("result item changed while stalled");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_allowed |-> rsp_answer_time == '0 && !rsp_oldest_dropped)
      else $error("none allowed with nonzero answer");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_oldest_dropped |-> rsp_answer_time == '0)
      else $error("record item with nonzero answer");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after accepting an item");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind pause_time_budget_tracker ptbt_checker u_ptbt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_answer_time    (rsp_answer_time),
   .rsp_none_allowed   (rsp_none_allowed),
   .rsp_oldest_dropped (rsp_oldest_dropped)
);
`default_nettype wire

@@ sim/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ptbt_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam longint TMAX = 64'h0000_00FF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]    kind;
      logic [TW-1:0] first;
      logic [TW-1:0] second;
   } pause_req_type;

   typedef struct packed {
      logic [TW-1:0] answer;
      logic          none;
      logic          dropped;
   } pause_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_type = REQ_RECORD;
   logic [TW-1:0]        req_time_first = '0;
   logic [TW-1:0]        req_time_second = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [TW-1:0]        rsp_answer_time;
   logic                 rsp_none_allowed;
   logic                 rsp_oldest_dropped;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WINDOW;
   logic [TW-1:0]        csr_wdata = '0;

   pause_time_budget_tracker dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mirror of the tracker state
   longint span_start [RING_DEPTH];
   longint span_end [RING_DEPTH];
   int     newest_idx = 0;
   int     oldest_idx = 1 % RING_DEPTH;
   int     live_spans = 0;
   longint win_len = 1000000;
   longint budget = 200000;

   pause_req_type pending_q [$];
   pause_rsp_type expected_q [$];
   int            mismatches = 0;

   function automatic void expire_spans(longint now);
      longint limit;
      limit = now - win_len;
      while (live_spans > 0 && span_end[oldest_idx] <= limit) begin
         oldest_idx = (oldest_idx + 1) % RING_DEPTH;
         live_spans--;
      end
   endfunction

   function automatic longint span_part(int s, longint limit);
      if (span_end[s] <= limit) return 0;
      return (span_start[s] > limit) ? span_end[s] - span_start[s] : span_end[s] - limit;
   endfunction

   function automatic longint busy_since(longint limit);
      longint sum;
      sum = 0;
      for (int k = 0; k < live_spans; k++) sum += span_part((oldest_idx + k) % RING_DEPTH, limit);
      return sum;
   endfunction

   function automatic longint max_allowed_pause(longint now);
      longint t, lim, d, floor_pt, st, en, steps;
      int     straddle;
      bit     have;
      t = budget;
      forever begin
         lim = now + t - win_len;
         d = t + busy_since(lim) - budget;
         if (d <= 0) return t;
         straddle = 0;
         have = 0;
         floor_pt = 0;
         for (int k = 0; k < live_spans; k++) begin
            st = span_start[(oldest_idx + k) % RING_DEPTH];
            en = span_end[(oldest_idx + k) % RING_DEPTH];
            if (st <= lim && lim < en) straddle++;
            if (st <= lim && (!have || st > floor_pt)) begin
               floor_pt = st;
               have = 1;
            end
            if (en <= lim && (!have || en > floor_pt)) begin
               floor_pt = en;
               have = 1;
            end
         end
         steps = (straddle == 1 && have) ? (lim - floor_pt) / d : 0;
         t -= (steps > 0) ? steps * d : d;
         if (t <= 0) return -1;
      end
   endfunction

   function automatic longint pause_delay(longint now, longint want);
      longint adj, lim, d, en, r;
      int     s;
      adj = (want > budget) ? budget : want;
      lim = now + adj - win_len;
      d = busy_since(lim) + adj - budget;
      if (d <= 0) return 0;
      for (int k = 0; k < live_spans; k++) begin
         s = (oldest_idx + k) % RING_DEPTH;
         en = span_end[s];
         if (en > lim) begin
            d -= span_part(s, lim);
            if (d <= 0) begin
               r = en + d + win_len - adj - now;
               if (r < 0) return 0;
               if (r > TMAX) return TMAX;
               return r;
            end
         end
      end
      return 0;
   endfunction

   function automatic pause_rsp_type predict_answer(pause_req_type it);
      pause_rsp_type res;
      longint        first, second, t;
      res = '0;
      first = longint'({24'b0, it.first});
      second = longint'({24'b0, it.second});
      case (it.kind)
         REQ_RECORD: begin
            expire_spans(second);
            newest_idx = (newest_idx + 1) % RING_DEPTH;
            if (live_spans >= RING_DEPTH) begin
               oldest_idx = (oldest_idx + 1) % RING_DEPTH;
               res.dropped = 1'b1;
            end else begin
               live_spans++;
            end
            span_start[newest_idx] = first;
            span_end[newest_idx] = second;
         end
         REQ_LONGEST: begin
            expire_spans(first);
            t = max_allowed_pause(first);
            if (t < 0) res.none = 1'b1;
            else res.answer = t[TW-1:0];
         end
         REQ_DELAY: begin
            expire_spans(first);
            t = pause_delay(first, second);
            res.answer = t[TW-1:0];
         end
         default: ;
      endcase
      return res;
   endfunction

   // request driver
   pause_req_type cur_req;
   int            burst_left = 0;
   int            gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_q.push_back(predict_answer(cur_req));
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            cur_req = pending_q.pop_front();
            req_type <= cur_req.kind;
            req_time_first <= cur_req.first;
            req_time_second <= cur_req.second;
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   int stall_mode = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      pause_rsp_type exp_rsp;
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 120);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: answer %0d none %0b dropped %0b",
                        rsp_answer_time, rsp_none_allowed, rsp_oldest_dropped);
            mismatches++;
         end else begin
            exp_rsp = expected_q.pop_front();
            if (rsp_answer_time !== exp_rsp.answer || rsp_none_allowed !== exp_rsp.none ||
                rsp_oldest_dropped !== exp_rsp.dropped) begin
               if (mismatches < 10)
                  $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                           exp_rsp.answer, exp_rsp.none, exp_rsp.dropped,
                           rsp_answer_time, rsp_none_allowed, rsp_oldest_dropped);
               mismatches++;
            end
         end
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, longint val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[TW-1:0];
      if (idx == CSR_WINDOW) win_len = val;
      else budget = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_req(logic [1:0] kind, longint first, longint second);
      pause_req_type it;
      it.kind = kind;
      it.first = first[TW-1:0];
      it.second = second[TW-1:0];
      pending_q.push_back(it);
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   longint cursor;

   task automatic run_phase(longint wl, longint bud, int n, int gap_max, int len_max);
      int     r;
      longint st, en, now, want;
      write_csr(CSR_WINDOW, wl);
      write_csr(CSR_BUDGET, bud);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         now = cursor + $urandom_range(0, len_max * 4);
         if (r < 55) begin
            st = cursor + $urandom_range(0, gap_max);
            en = st + $urandom_range(1, len_max);
            cursor = en;
            push_req(REQ_RECORD, st, en);
         end else if (r < 75) begin
            push_req(REQ_LONGEST, now, {$urandom, $urandom} & TMAX);
         end else if (r < 94) begin
            case ($urandom_range(0, 3))
               0: want = budget;
               1: want = {$urandom, $urandom} & TMAX;
               default: want = $urandom_range(0, len_max * 4);
            endcase
            push_req(REQ_DELAY, now, want);
         end else if (r < 97) begin
            push_req(REQ_UNUSED, {$urandom, $urandom} & TMAX, {$urandom, $urandom} & TMAX);
         end else begin
            push_req($urandom_range(0, 1) ? REQ_LONGEST : REQ_DELAY,
                     {$urandom, $urandom} & TMAX, $urandom_range(0, len_max));
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_csr(CSR_WINDOW, 1000000);
      write_csr(CSR_BUDGET, 200000);
      push_req(REQ_LONGEST, 0, 0);
      push_req(REQ_DELAY, 0, 0);
      push_req(REQ_DELAY, 0, TMAX);
      push_req(REQ_UNUSED, TMAX, TMAX);
      push_req(REQ_RECORD, 100, 50100);
      push_req(REQ_RECORD, 60000, 160000);
      push_req(REQ_RECORD, 170000, 250000);
      push_req(REQ_LONGEST, 250000, 0);
      push_req(REQ_DELAY, 250000, 50000);
      push_req(REQ_RECORD, 260000, 255000);
      push_req(REQ_LONGEST, 260000, 0);
      push_req(REQ_DELAY, 260000, 200000);
      push_req(REQ_RECORD, TMAX, 270000);
      push_req(REQ_LONGEST, 270000, 0);
      push_req(REQ_DELAY, 270000, 1000);
      push_req(REQ_RECORD, 0, 0);
      push_req(REQ_LONGEST, TMAX, 0);
      push_req(REQ_DELAY, TMAX, TMAX);
      push_req(REQ_RECORD, 1000, 2000);
      push_req(REQ_LONGEST, 2000, 0);
      wait_drained();
      cursor = longint'($urandom) * 64 + (longint'(1) << 39);
      run_phase(1000000, 200000, 400, 8000, 4000);
      run_phase(50000, 5000, 250, 2000, 800);
      run_phase(TMAX, TMAX, 150, 1000, 500);
      run_phase(1, 0, 150, 100, 50);
      run_phase(300000, 100000, 180, 5000, 3000);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #1_000_000_000;
      $display("tb: failure");
      $finish;
   end
endmodule

@@ filelist.f @@
src/ptbt_pkg.sv
src/ptbt_ctrl.sv
src/ptbt_datapath.sv
src/pause_time_budget_tracker.sv
src/ptbt_checker.sv
sim/tb_top.sv
